/* rtl/sha_pkg.sv */
// Package with the SHA-256 constants, round functions and shared types.
`default_nettype none
package sha_pkg;

	typedef logic [0:7][31:0] hash_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMP,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic       push;
		logic       push_word;
		logic [7:0] byte_val;
		logic       start;
		logic       init;
	} comp_ctrl_t;

	localparam hash_t INIT_H = hash_t'{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [5:0] LENGTH_MARK = 6'd56;
	localparam logic [5:0] LAST_SLOT = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [1:0] LAST_INDEX = 2'd3;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] i);
		case (i)
			6'd0:  round_k = 32'h428a2f98;
			6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;
			6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;
			6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;
			6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;
			6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;
			6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;
			6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;
			6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;
			6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;
			6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;
			6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;
			6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;
			6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;
			6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;
			6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;
			6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;
			6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;
			6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;
			6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;
			6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;
			6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;
			6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;
			6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;
			6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;
			6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;
			6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;
			6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;
			6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;
			6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;
			6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;
			6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;
			6'd63: round_k = 32'hc67178f2;
			default: round_k = 32'h0;
		endcase
	endfunction

endpackage
`default_nettype wire

/* rtl/sha_in_if.sv */
// Input channel: one message byte or a finish request per transaction.
`default_nettype none
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/sha_out_if.sv */
// Output channel: one 64-bit quarter of the digest per transaction.
`default_nettype none
interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;
	logic        length_overflow;

	modport source (output valid, output digest_word, output word_index,
		output last_word, output length_overflow, input ready);
	modport sink (input valid, input digest_word, input word_index,
		input last_word, input length_overflow, output ready);
endinterface
`default_nettype wire

/* rtl/sha_comp.sv */
// Compression unit: schedule window, one SHA-256 round per cycle, chaining words.
`default_nettype none
module sha_comp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sha_pkg::comp_ctrl_t ctrl,
	output logic                    done,
	output sha_pkg::hash_t          h
);
	import sha_pkg::*;

	logic [23:0] stage_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	hash_t       h_q;
	logic [5:0]  rnd_q;
	logic        running_q;
	logic        fin_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;
	logic [31:0] w_new;

	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + big_sigma1(v_q[4]) + ch + round_k(rnd_q) + w_q[0];
		t2 = big_sigma0(v_q[0]) + maj;
		// The window always holds w[t..t+15], so the next word is formed in place.
		w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (ctrl.push_word) begin
				for (int i = 0; i < 15; i++) begin
					w_q[i] <= w_q[i + 1];
				end
				w_q[15] <= {stage_q, ctrl.byte_val};
			end else begin
				stage_q <= {stage_q[15:0], ctrl.byte_val};
			end
		end else if (running_q) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (ctrl.start) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (running_q) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q       <= INIT_H;
			rnd_q     <= '0;
			running_q <= 1'b0;
			fin_q     <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (ctrl.start) begin
				running_q <= 1'b1;
				rnd_q     <= '0;
			end else if (running_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND) begin
					running_q <= 1'b0;
					fin_q     <= 1'b1;
				end
			end
			if (ctrl.init) begin
				h_q <= INIT_H;
			end else if (fin_q) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
		end
	end

	assign done = fin_q;
	assign h    = h_q;

endmodule
`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// SHA-256 over a byte stream: top level with the sequencer and the digest register.
//
// The msg channel carries one transaction per message byte (kind 0) or a
// finish request (kind 1). The digest channel returns four transactions per
// finish, the 64-bit quarters of the digest, most significant first, with
// last_word set on the fourth and length_overflow on all four.
// A byte is taken whenever the channel is ready, which it is only while idle.
// The byte that completes a 64-byte block starts the compression: 64 rounds
// on one shared round unit, one round per cycle, plus a fold of the result
// into the chaining words, and the channel is not ready again until that fold.
// A finish writes the pad byte, zeros and the bit length one byte per cycle,
// apart from the compressions that stall it, and runs one or two compressions.
// The four words leave one per cycle from an output register; a stalled
// receiver holds the sequencer in the emit phase until each word is taken.
// After the last word has been loaded the block starts a new message with the
// initial hash values.
// Reset puts the chaining words to the initial hash values and clears the
// byte count, the length flag and all control state.
`default_nettype none
module sha256_stream_hasher (
	input  wire logic clk,
	input  wire logic arst_n,
	sha_in_if.sink    msg,
	sha_out_if.source digest
);
	import sha_pkg::*;

	state_t      state_q;
	state_t      state_d;
	state_t      ret_q;
	state_t      ret_d;
	logic        ret_we;

	logic [5:0]  fill_q;
	logic [60:0] msg_q;
	logic        ovf_q;
	logic        wrap_q;
	logic [63:0] len_q;
	logic [1:0]  idx_q;

	logic        out_valid_q;
	logic [63:0] out_word_q;
	logic [1:0]  out_idx_q;
	logic        out_ovf_q;

	comp_ctrl_t  ctrl;
	logic        comp_done;
	hash_t       h;

	logic        msg_inc;
	logic        ovf_set;
	logic        fin_load;
	logic        len_shift;
	logic        emit_load;
	logic        msg_clear;

	sha_comp u_comp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.done   (comp_done),
		.h      (h)
	);

	always_comb begin
		state_d   = state_q;
		ret_d     = ret_q;
		ret_we    = 1'b0;
		ctrl      = '0;
		msg.ready = 1'b0;
		msg_inc   = 1'b0;
		ovf_set   = 1'b0;
		fin_load  = 1'b0;
		len_shift = 1'b0;
		emit_load = 1'b0;
		msg_clear = 1'b0;
		ctrl.push_word = (fill_q[1:0] == 2'b11);
		case (state_q)
			ST_IDLE: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					if (!msg.kind) begin
						if (&msg_q) begin
							ovf_set = 1'b1;
						end else begin
							ctrl.push     = 1'b1;
							ctrl.byte_val = msg.data_byte;
							msg_inc       = 1'b1;
							if (fill_q == LAST_SLOT) begin
								ctrl.start = 1'b1;
								ret_d      = ST_IDLE;
								ret_we     = 1'b1;
								state_d    = ST_COMP;
							end
						end
					end else begin
						ctrl.push     = 1'b1;
						ctrl.byte_val = PAD_BYTE;
						fin_load      = 1'b1;
						state_d       = ST_PAD_ZERO;
						if (fill_q == LAST_SLOT) begin
							ctrl.start = 1'b1;
							ret_d      = ST_PAD_ZERO;
							ret_we     = 1'b1;
							state_d    = ST_COMP;
						end
					end
				end
			end
			ST_PAD_ZERO: begin
				if (!wrap_q && fill_q == LENGTH_MARK) begin
					state_d = ST_PAD_LEN;
				end else begin
					ctrl.push     = 1'b1;
					ctrl.byte_val = 8'h00;
					if (fill_q == LAST_SLOT) begin
						ctrl.start = 1'b1;
						ret_d      = ST_PAD_ZERO;
						ret_we     = 1'b1;
						state_d    = ST_COMP;
					end
				end
			end
			ST_PAD_LEN: begin
				ctrl.push     = 1'b1;
				ctrl.byte_val = len_q[63:56];
				len_shift     = 1'b1;
				if (fill_q == LAST_SLOT) begin
					ctrl.start = 1'b1;
					ret_d      = ST_EMIT;
					ret_we     = 1'b1;
					state_d    = ST_COMP;
				end
			end
			ST_COMP: begin
				if (comp_done) begin
					state_d = ret_q;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || digest.ready) begin
					emit_load = 1'b1;
					if (idx_q == LAST_INDEX) begin
						ctrl.init = 1'b1;
						msg_clear = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			msg_q       <= '0;
			ovf_q       <= 1'b0;
			wrap_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ret_we) begin
				ret_q <= ret_d;
			end
			if (ctrl.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (msg_clear) begin
				msg_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (msg_inc) begin
					msg_q <= msg_q + 61'd1;
				end
				if (ovf_set) begin
					ovf_q <= 1'b1;
				end
			end
			// A finish whose pad byte lands in the length field spills into one more block.
			if (ctrl.start) begin
				wrap_q <= 1'b0;
			end else if (fin_load) begin
				wrap_q <= (fill_q >= LENGTH_MARK);
			end
			if (emit_load) begin
				idx_q       <= idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			len_q <= {msg_q, 3'b000};
		end else if (len_shift) begin
			len_q <= {len_q[55:0], 8'h00};
		end
		if (emit_load) begin
			out_word_q <= {h[{idx_q, 1'b0}], h[{idx_q, 1'b1}]};
			out_idx_q  <= idx_q;
			out_ovf_q  <= ovf_q;
		end
	end

	assign digest.valid           = out_valid_q;
	assign digest.digest_word     = out_word_q;
	assign digest.word_index      = out_idx_q;
	assign digest.last_word       = (out_idx_q == LAST_INDEX);
	assign digest.length_overflow = out_ovf_q;

endmodule
`default_nettype wire
